>>> rtl/fcss_pkg.sv
package fcss_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = 9;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int STEP_W     = $clog2(FRAC_BITS);
	localparam int PADDR_W    = 3;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_EDGE_COUNT = 3'd0;

	typedef struct packed {
		logic                         req_type;
		logic [IDX_W-1:0]             entry_index;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic                         skip_enable;
		logic [IDX_W-1:0]             skip_index;
	} fcss_in_t;

	typedef struct packed {
		logic                         found;
		logic [IDX_W-1:0]             hit_index;
		logic [FRAC_BITS-1:0]         t_frac;
		logic [FRAC_BITS-1:0]         u_frac;
		logic signed [COORD_BITS-1:0] cross_x;
		logic signed [COORD_BITS-1:0] cross_y;
	} fcss_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_DIV_T,
		ST_DIV_U,
		ST_MUL,
		ST_FIN
	} fcss_state_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

>>> rtl/fcss_div.sv
module fcss_div
	import fcss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [PROD_W-1:0] den,
	output logic              done,
	output logic [FRAC_BITS-1:0] quot
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [PROD_W:0]   rem_q;
	logic [PROD_W:0]   den_q;
	logic [PROD_W:0]   rem_sh;
	logic              ge;

	// one restoring step: shift, compare, subtract
	assign rem_sh = {rem_q[PROD_W-1:0], 1'b0};
	assign ge     = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// advance the remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= {1'b0, den};
			quot  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - den_q) : rem_sh;
			quot  <= {quot[FRAC_BITS-2:0], ge};
		end
	end

endmodule

>>> rtl/first_crossing_segment_search_top.sv
// Load item: the entry is written on accept, then an all-zero result is issued from ST_FIN.
// Query item: a table scan of up to min(edge_count, MAX_EDGES) entries (one entry a
// cycle through a three-stage product pipeline), then the shared serial divider for
// t and then u, then ST_MUL forms the products for the crossing point.
// One item at a time; the result register lets the next item enter while it waits.
// Reset clears control state and edge_count; table entries are undefined until loaded.
module first_crossing_segment_search_top
	import fcss_pkg::*;
#(
	parameter int MAX_EDGES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fcss_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fcss_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	fcss_state_t state_q, state_d;

	logic [CNT_W-1:0] edge_count_q;
	fcss_in_t         req_q;
	logic signed [DIFF_W-1:0] rx_q, ry_q;
	logic [CNT_W-1:0] scan_q, n_q;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [PROD_W-1:0] rcs_abs_q, tnum_abs_q, unum_abs_q;
	logic [FRAC_BITS-1:0] tf_q, uf_q;
	logic signed [PROD_W-1:0] mx_q, my_q;
	logic             out_valid_q;
	fcss_out_t        out_q;

	logic [4*COORD_BITS-1:0] mem [MAX_EDGES];
	logic [4*COORD_BITS-1:0] rd_s1;
	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [PROD_W-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [CROSS_W-1:0] rcs_s3, tnum_s3, unum_s3;

	logic accept, issue, skip_hit, hit, scan_empty, emit;
	logic div_start, div_done;
	logic [PROD_W-1:0] div_num;
	logic [FRAC_BITS-1:0] div_quot;
	logic [CNT_W-1:0] n_d;

	assign accept = in_valid && !in_stall;
	assign pready = 1'b1;

	// config register write and read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_EDGE_COUNT) begin
			edge_count_q <= pwdata[CNT_W-1:0];
		end
	end
	assign prdata = (paddr == REG_EDGE_COUNT) ? {{(32-CNT_W){1'b0}}, edge_count_q} : '0;

	// clamp the scan length to the table depth
	always_comb begin
		n_d = edge_count_q;
		if (32'(edge_count_q) > MAX_EDGES) n_d = CNT_W'(MAX_EDGES);
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == REQ_LOAD && 32'(in_data.entry_index) < MAX_EDGES) begin
			mem[AW'(in_data.entry_index)] <= {in_data.start_x, in_data.start_y,
				in_data.end_x, in_data.end_y};
		end
		if (issue) rd_s1 <= mem[AW'(scan_q)];
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			rx_q  <= DIFF_W'(in_data.end_x) - DIFF_W'(in_data.start_x);
			ry_q  <= DIFF_W'(in_data.end_y) - DIFF_W'(in_data.start_y);
			n_q   <= n_d;
		end
	end

	assign skip_hit = req_q.skip_enable && scan_q == {1'b0, req_q.skip_index};

	// scan pipeline: read, products, cross differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			scan_q <= '0;
		end else begin
			v_s1 <= issue && !skip_hit;
			v_s2 <= v_s1 && state_q == ST_SCAN && !hit;
			v_s3 <= v_s2 && state_q == ST_SCAN && !hit;
			if (accept) scan_q <= '0;
			else if (issue) scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DIFF_W-1:0] sx, sy, wx, wy;
		sx = DIFF_W'($signed(rd_s1[2*COORD_BITS-1 -: COORD_BITS]))
			- DIFF_W'($signed(rd_s1[4*COORD_BITS-1 -: COORD_BITS]));
		sy = DIFF_W'($signed(rd_s1[COORD_BITS-1:0]))
			- DIFF_W'($signed(rd_s1[3*COORD_BITS-1 -: COORD_BITS]));
		wx = DIFF_W'($signed(rd_s1[4*COORD_BITS-1 -: COORD_BITS])) - DIFF_W'(req_q.start_x);
		wy = DIFF_W'($signed(rd_s1[3*COORD_BITS-1 -: COORD_BITS])) - DIFF_W'(req_q.start_y);
		idx_s1 <= scan_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		a_s2 <= rx_q * sy;
		b_s2 <= ry_q * sx;
		c_s2 <= wx * sy;
		d_s2 <= wy * sx;
		e_s2 <= wx * ry_q;
		f_s2 <= wy * rx_q;
		rcs_s3  <= CROSS_W'(a_s2) - CROSS_W'(b_s2);
		tnum_s3 <= CROSS_W'(c_s2) - CROSS_W'(d_s2);
		unum_s3 <= CROSS_W'(e_s2) - CROSS_W'(f_s2);
	end

	// proper crossing test, sign of rcs folded into the compares
	always_comb begin
		hit = 1'b0;
		if (v_s3 && state_q == ST_SCAN) begin
			if (rcs_s3 > 0)
				hit = tnum_s3 > 0 && tnum_s3 < rcs_s3 && unum_s3 > 0 && unum_s3 < rcs_s3;
			else if (rcs_s3 < 0)
				hit = tnum_s3 < 0 && tnum_s3 > rcs_s3 && unum_s3 < 0 && unum_s3 > rcs_s3;
		end
	end

	assign scan_empty = scan_q >= n_q && !v_s1 && !v_s2 && !v_s3;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = (in_data.req_type == REQ_QUERY) ? ST_SCAN : ST_FIN;
			ST_SCAN:  if (hit) state_d = ST_HIT;
			          else if (scan_empty) state_d = ST_FIN;
			ST_HIT:   state_d = ST_DIV_T;
			ST_DIV_T: if (div_done) state_d = ST_DIV_U;
			ST_DIV_U: if (div_done) state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue     = 1'b0;
		div_start = 1'b0;
		div_num   = unum_abs_q;
		emit      = 1'b0;
		case (state_q)
			ST_SCAN:  issue = !hit && scan_q < n_q;
			ST_HIT: begin
				div_start = 1'b1;
				div_num   = tnum_abs_q;
			end
			ST_DIV_T: div_start = div_done;
			ST_FIN:   emit = !out_valid_q || !out_stall;
			default:  issue = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) found_q <= 1'b0;
			else if (hit) found_q <= 1'b1;
		end
	end

	// capture hit magnitudes, quotients and products
	always_ff @(posedge clk) begin
		if (hit) begin
			hit_idx_q  <= idx_s3;
			rcs_abs_q  <= rcs_s3[CROSS_W-1] ? PROD_W'(-rcs_s3) : PROD_W'(rcs_s3);
			tnum_abs_q <= rcs_s3[CROSS_W-1] ? PROD_W'(-tnum_s3) : PROD_W'(tnum_s3);
			unum_abs_q <= rcs_s3[CROSS_W-1] ? PROD_W'(-unum_s3) : PROD_W'(unum_s3);
		end
		if (state_q == ST_DIV_T && div_done) tf_q <= div_quot;
		if (state_q == ST_DIV_U && div_done) uf_q <= div_quot;
		if (state_q == ST_MUL) begin
			mx_q <= $signed({1'b0, tf_q}) * rx_q;
			my_q <= $signed({1'b0, tf_q}) * ry_q;
		end
	end

	fcss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (rcs_abs_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// crossing point, truncated toward zero
	function automatic logic signed [COORD_BITS-1:0] cross_pt(
		input logic signed [COORD_BITS-1:0] p,
		input logic signed [PROD_W-1:0]     m
	);
		logic signed [CROSS_W-1:0] v;
		logic signed [CROSS_W-1:0] q;
		v = (CROSS_W'(p) <<< FRAC_BITS) + CROSS_W'(m);
		q = v >>> FRAC_BITS;
		if (v[CROSS_W-1] && v[FRAC_BITS-1:0] != '0) q = q + 1'b1;
		return q[COORD_BITS-1:0];
	endfunction

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// build the result word, all zero unless a query found a crossing
	always_ff @(posedge clk) begin
		fcss_out_t res;
		res = '0;
		if (found_q && req_q.req_type == REQ_QUERY) begin
			res.found     = 1'b1;
			res.hit_index = hit_idx_q;
			res.t_frac    = tf_q;
			res.u_frac    = uf_q;
			res.cross_x   = cross_pt(req_q.start_x, mx_q);
			res.cross_y   = cross_pt(req_q.start_y, my_q);
		end
		if (emit) out_q <= res;
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
